// ===== design/rsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the radial stick deadzone pipeline.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned OUT_FRAC_BITS = 14;
  localparam int unsigned QW            = OUT_FRAC_BITS + 1;   // quotient bits
  localparam int unsigned NW            = OUT_FRAC_BITS + 34;  // dividend width
  localparam int unsigned EXT_W         = (QW > 16) ? QW : 16;
  localparam int unsigned SQ_CELLS      = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [15:0] INNER_RESET = 16'd2500;
  localparam logic [15:0] OUTER_RESET = 16'd30000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INNER = 2'd0,
    REG_OUTER = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] scaled_x;
    logic signed [15:0] scaled_y;
    logic               in_deadzone;
  } out_item_t;

  // square root cell payload
  typedef struct packed {
    logic               vld;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        v;
    logic [31:0]        res;
  } sq_t;

  // divider cell payload, both components share the divisor
  typedef struct packed {
    logic            vld;
    logic            dz;
    logic            zr;
    logic            nx;
    logic            ny;
    logic [NW-1:0]   rx;
    logic [NW-1:0]   ry;
    logic [NW-1:0]   ds;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
  } dv_t;

endpackage
`default_nettype wire

// ===== design/rsd_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_sqrt_cell
// One result bit of the integer square root, registered.
// ----------------------------------------------------------------------------
module rsd_sqrt_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [31:0]  bit_i,
  input  wire rsd_pkg::sq_t in_i,
  output rsd_pkg::sq_t      out_o
);
  import rsd_pkg::*;

  sq_t         cell_d, cell_q;
  logic [31:0] trial;
  logic        ge;

  always_comb begin
    trial      = in_i.res + bit_i;
    ge         = in_i.v >= trial;
    cell_d     = in_i;
    cell_d.v   = ge ? (in_i.v - trial) : in_i.v;
    cell_d.res = ge ? ((in_i.res >> 1) + bit_i) : (in_i.res >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule
`default_nettype wire

// ===== design/rsd_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_div_cell
// One restoring division step for both components, registered.
// ----------------------------------------------------------------------------
module rsd_div_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire rsd_pkg::dv_t in_i,
  output rsd_pkg::dv_t      out_o
);
  import rsd_pkg::*;

  dv_t  cell_d, cell_q;
  logic gx, gy;

  always_comb begin
    gx        = in_i.rx >= in_i.ds;
    gy        = in_i.ry >= in_i.ds;
    cell_d    = in_i;
    cell_d.rx = gx ? (in_i.rx - in_i.ds) : in_i.rx;
    cell_d.ry = gy ? (in_i.ry - in_i.ds) : in_i.ry;
    cell_d.qx = {in_i.qx[QW-2:0], gx};
    cell_d.qy = {in_i.qy[QW-2:0], gy};
    cell_d.ds = in_i.ds >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule
`default_nettype wire

// ===== design/radial_stick_deadzone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radial_stick_deadzone
// Scaled radial deadzone for a two-axis stick sample.
// ----------------------------------------------------------------------------
// Input items (axis_x, axis_y) enter on in_valid_i/in_ready_o; result items
// (scaled_x, scaled_y, in_deadzone) leave on out_valid_o/out_ready_i.
// The datapath is a chain of registered cells: one squaring stage, sixteen
// square root cells (one root bit each), a fraction stage, a multiply stage,
// OUT_FRAC_BITS+1 division cells (one quotient bit each) and the output
// register. One item is accepted every cycle while the receiver takes
// results. When the output register holds an item that is not taken, the
// whole chain holds and in_ready_o drops; it resumes the cycle the item is
// taken. Reset empties the chain and loads inner_deadzone = 2500 and
// outer_limit = 30000. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while no item is in flight,
// which the block itself does not enforce; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module radial_stick_deadzone (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire rsd_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output rsd_pkg::out_item_t                out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]                  cfg_data_i
);
  import rsd_pkg::*;

  typedef struct packed {
    logic               vld;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        xx;
    logic [31:0]        yy;
  } sqr_t;

  typedef struct packed {
    logic        vld;
    logic        dz;
    logic        zr;
    logic        nx;
    logic        ny;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] num;
    logic [15:0] den;
    logic [15:0] len;
  } frac_t;

  typedef struct packed {
    logic        vld;
    logic        dz;
    logic        zr;
    logic        nx;
    logic        ny;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] dl;
  } mul_t;

  logic        adv;
  logic [15:0] inner_q, outer_q;
  sqr_t        sqr_d, sqr_q;
  frac_t       frac_d, frac_q;
  mul_t        mul_d, mul_q;
  sq_t         sq_chain [SQ_CELLS+1];
  dv_t         dv_chain [QW+1];
  logic        out_valid_q;
  out_item_t   out_d, out_q;
  logic [15:0] len;
  logic [EXT_W-1:0] qxe, qye, sxe, sye;

  // the whole chain moves unless a result waits at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_RESET;
      outer_q <= OUTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INNER: inner_q <= cfg_data_i;
        REG_OUTER: outer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sqr_d.vld = in_valid_i;
    sqr_d.x   = in_data_i.axis_x;
    sqr_d.y   = in_data_i.axis_y;
    sqr_d.xx  = $unsigned(32'(in_data_i.axis_x * in_data_i.axis_x));
    sqr_d.yy  = $unsigned(32'(in_data_i.axis_y * in_data_i.axis_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqr_q <= '0;
    end else if (adv) begin
      sqr_q <= sqr_d;
    end
  end

  always_comb begin
    sq_chain[0].vld = sqr_q.vld;
    sq_chain[0].x   = sqr_q.x;
    sq_chain[0].y   = sqr_q.y;
    sq_chain[0].v   = sqr_q.xx + sqr_q.yy;
    sq_chain[0].res = '0;
  end

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    rsd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .bit_i  (32'(1) << (2 * (SQ_CELLS - 1 - k))),
      .in_i   (sq_chain[k]),
      .out_o  (sq_chain[k+1])
    );
  end

  assign len = sq_chain[SQ_CELLS].res[15:0];

  always_comb begin
    frac_d.vld = sq_chain[SQ_CELLS].vld;
    frac_d.dz  = len < inner_q;
    frac_d.zr  = len == 16'd0;
    frac_d.nx  = sq_chain[SQ_CELLS].x[15];
    frac_d.ny  = sq_chain[SQ_CELLS].y[15];
    frac_d.mx  = sq_chain[SQ_CELLS].x[15] ? 16'(-sq_chain[SQ_CELLS].x)
                                          : 16'(sq_chain[SQ_CELLS].x);
    frac_d.my  = sq_chain[SQ_CELLS].y[15] ? 16'(-sq_chain[SQ_CELLS].y)
                                          : 16'(sq_chain[SQ_CELLS].y);
    frac_d.len = len;
    if (outer_q <= inner_q) begin
      frac_d.num = 16'd1;
      frac_d.den = 16'd1;
    end else begin
      frac_d.den = outer_q - inner_q;
      frac_d.num = ((len - inner_q) > frac_d.den) ? frac_d.den : (len - inner_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
    end else if (adv) begin
      frac_q <= frac_d;
    end
  end

  always_comb begin
    mul_d.vld = frac_q.vld;
    mul_d.dz  = frac_q.dz;
    mul_d.zr  = frac_q.zr;
    mul_d.nx  = frac_q.nx;
    mul_d.ny  = frac_q.ny;
    mul_d.px  = frac_q.mx * frac_q.num;
    mul_d.py  = frac_q.my * frac_q.num;
    mul_d.dl  = frac_q.den * frac_q.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else if (adv) begin
      mul_q <= mul_d;
    end
  end

  // dividend 2n + d, divisor 2d aligned to the top quotient bit
  always_comb begin
    dv_chain[0].vld = mul_q.vld;
    dv_chain[0].dz  = mul_q.dz;
    dv_chain[0].zr  = mul_q.zr;
    dv_chain[0].nx  = mul_q.nx;
    dv_chain[0].ny  = mul_q.ny;
    dv_chain[0].rx  = (NW'(mul_q.px) << (OUT_FRAC_BITS + 1)) + NW'(mul_q.dl);
    dv_chain[0].ry  = (NW'(mul_q.py) << (OUT_FRAC_BITS + 1)) + NW'(mul_q.dl);
    dv_chain[0].ds  = NW'(mul_q.dl) << QW;
    dv_chain[0].qx  = '0;
    dv_chain[0].qy  = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    rsd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .in_i   (dv_chain[k]),
      .out_o  (dv_chain[k+1])
    );
  end

  always_comb begin
    qxe = EXT_W'(dv_chain[QW].qx);
    qye = EXT_W'(dv_chain[QW].qy);
    sxe = dv_chain[QW].nx ? (~qxe + 1'b1) : qxe;
    sye = dv_chain[QW].ny ? (~qye + 1'b1) : qye;
    out_d.in_deadzone = dv_chain[QW].dz;
    if (dv_chain[QW].dz || dv_chain[QW].zr) begin
      out_d.scaled_x = '0;
      out_d.scaled_y = '0;
    end else begin
      out_d.scaled_x = sxe[15:0];
      out_d.scaled_y = sye[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_chain[QW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_deadzone |->
      out_data_o.scaled_x == 16'sd0 && out_data_o.scaled_y == 16'sd0)
    else $error("deadzone item with nonzero output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("empty output but input stalled");

endmodule
`default_nettype wire

// ===== bench/radial_stick_deadzone_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_stick_deadzone_checker
// Watches both item channels and the register port of the radial deadzone,
// computes the expected scaled vector for every accepted sample and compares
// each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_checker
  import rsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   deadzone_seen_o
);

  logic [15:0] inner_q, outer_q;
  out_item_t   scaled_fifo[$];

  assign pending_o = scaled_fifo.size();

  function automatic logic [31:0] root_floor(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] rescale(logic signed [15:0] c, longint unsigned num,
                                          longint unsigned den, longint unsigned len);
    longint unsigned m, n, d, q;
    m = (c < 0) ? longint'(-int'(c)) : longint'(c);
    n = m * num * (64'd1 << OUT_FRAC_BITS);
    d = den * len;
    q = (2 * n + d) / (2 * d);
    if (c < 0) q = 64'd0 - q;
    return q[15:0];
  endfunction

  function automatic out_item_t predict_scaled(in_item_t s);
    out_item_t       r;
    logic [31:0]     sq, len;
    longint unsigned num, den;
    sq  = 32'(int'(s.axis_x) * int'(s.axis_x)) + 32'(int'(s.axis_y) * int'(s.axis_y));
    len = root_floor(sq);
    r   = '0;
    if (len < inner_q) begin
      r.in_deadzone = 1'b1;
      return r;
    end
    if (len == 0) return r;
    if (outer_q <= inner_q) begin
      num = 1;
      den = 1;
    end else begin
      den = outer_q - inner_q;
      num = len - inner_q;
      if (num > den) num = den;
    end
    r.scaled_x = rescale(s.axis_x, num, den, len);
    r.scaled_y = rescale(s.axis_y, num, den, len);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      inner_q         <= INNER_RESET;
      outer_q         <= OUTER_RESET;
      fail_count_o    <= 0;
      deadzone_seen_o <= 0;
      scaled_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_INNER) inner_q <= cfg_data_i;
        else if (cfg_idx_i == REG_OUTER) outer_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i) scaled_fifo.push_back(predict_scaled(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (scaled_fifo.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = scaled_fifo.pop_front();
          if (e.in_deadzone) deadzone_seen_o <= deadzone_seen_o + 1;
          if (e.scaled_x !== out_data_i.scaled_x || e.scaled_y !== out_data_i.scaled_y ||
              e.in_deadzone !== out_data_i.in_deadzone) begin
            $display("%0t: mismatch, expected x=%0d y=%0d dz=%0d, actual x=%0d y=%0d dz=%0d",
                     $time, e.scaled_x, e.scaled_y, e.in_deadzone,
                     out_data_i.scaled_x, out_data_i.scaled_y, out_data_i.in_deadzone);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/radial_stick_deadzone_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_stick_deadzone_tb
// Drives directed and random stick samples through several deadzone settings
// with random gaps on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_tb;
  import rsd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic                 clk_i, rst_ni;
  logic                 in_valid_i, in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o, out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_data_i;
  int                   fail_count, pending, deadzone_seen;
  int                   idle_cycles, sample_count, phase_count;
  bit                   timed_out;

  radial_stick_deadzone DUT (.*);

  radial_stick_deadzone_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count),
    .pending_o(pending), .deadzone_seen_o(deadzone_seen)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog over cycles with no accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver: random stall before each item
  initial begin
    int stall;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if (phase_count == 2) stall = 0;
      if (stall == 0) begin
        out_ready_i <= 1;
      end else begin
        out_ready_i <= 0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_sample(logic [15:0] x, logic [15:0] y, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    // drop valid during the gap so the previous item is not taken again
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= '{axis_x: x, axis_y: y};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sample_count++;
    if (no_gap) return;
    in_valid_i <= 0;
  endtask

  task automatic drain_and_pause();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [15:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = (i % 200) < 40;
      send_sample(random_axis(), random_axis(), burst);
    end
    drain_and_pause();
  endtask

  initial begin
    logic [15:0] inner_set[6];
    logic [15:0] outer_set[6];
    inner_set = '{16'd2500, 16'd0, 16'd46341, 16'd20000, 16'd100, 16'd0};
    outer_set = '{16'd30000, 16'd46341, 16'd1, 16'd10000, 16'd400, 16'd1};
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = REG_INNER;
    cfg_data_i = 0;
    idle_cycles = 0;
    sample_count = 0;
    phase_count = 0;
    timed_out = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    fork
      begin
        // directed: extremes at reset settings
        send_sample(16'h0000, 16'h0000, 0);
        send_sample(16'h7fff, 16'h7fff, 0);
        send_sample(16'h8000, 16'h8000, 0);
        send_sample(16'h8000, 16'h7fff, 0);
        send_sample(16'h7fff, 16'h0000, 0);
        send_sample(16'h0000, 16'h8000, 0);
        send_sample(16'd2499, 16'd0, 0);
        send_sample(16'd2500, 16'd0, 0);
        send_sample(16'hffff, 16'h0001, 0);
        send_sample(16'd30000, 16'd0, 0);
        send_sample(16'd1000, 16'hfc18, 0);
        drain_and_pause();
        // unknown index is dropped
        cfg_we_i <= 1;
        cfg_idx_i <= CFG_IDX_W'(3);
        cfg_data_i <= 16'hffff;
        @(posedge clk_i);
        cfg_we_i <= 0;
        for (int p = 0; p < 6; p++) begin
          phase_count = p;
          write_reg(REG_INNER, inner_set[p]);
          write_reg(REG_OUTER, outer_set[p]);
          send_sample(16'h0000, 16'h0000, 0);
          send_sample(16'h8000, 16'h8000, 0);
          send_sample(16'h0001, 16'h0000, 0);
          random_phase(p == 0 ? 800 : 230);
        end
        if (fail_count == 0) begin
          $display("Covered %0d samples over 6 register settings, %0d in the deadzone.",
                   sample_count, deadzone_seen);
          $display("CHECK OK");
        end else begin
          $display("Covered %0d samples, %0d failures.", sample_count, fail_count);
          $display("CHECK FAILED");
        end
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1;
      end
    join_any
    if (timed_out) $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rsd_pkg.sv
design/rsd_sqrt_cell.sv
design/rsd_div_cell.sv
design/radial_stick_deadzone.sv
bench/radial_stick_deadzone_checker.sv
bench/radial_stick_deadzone_tb.sv
